### src/timestamp_clip_selector_top_macros.svh
// Assertion macros for the timestamp clip selector.
// Used by timestamp_clip_selector_top.sv; expects i_clk and i_rst_n in scope.
`ifndef TIMESTAMP_CLIP_SELECTOR_TOP_MACROS_SVH
`define TIMESTAMP_CLIP_SELECTOR_TOP_MACROS_SVH

// Checked at every clock edge outside reset.
`define TCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define TCS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/tcs_pkg.sv
// Shared types and constants of the timestamp clip selector.
// No dependencies; used by timestamp_clip_selector_top.
`default_nettype none

package tcs_pkg;

    localparam int TS_W   = 64;
    localparam int CFG_W  = 32;
    localparam int ACC_W  = 38;   // k * stride, k up to 63
    localparam int BEST_W = 34;   // holds the start gap of 1e10

    localparam logic [BEST_W-1:0] GAP_START = 34'd10000000000;

    localparam logic [1:0] CFG_CLIP_LENGTH = 2'd0;
    localparam logic [1:0] CFG_STRIDE_Q8   = 2'd1;
    localparam logic [1:0] CFG_MAX_GAP     = 2'd2;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] STAT_MATCH     = 2'd0;
    localparam logic [1:0] STAT_UNMATCHED = 2'd1;
    localparam logic [1:0] STAT_EMPTY     = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TGT,
        ST_READ,
        ST_GAP,
        ST_CMP,
        ST_NEXT,
        ST_OUT_MS,
        ST_OUT_RING,
        ST_OUT_LOAD,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

### src/timestamp_clip_selector_top.sv
// Timestamp clip selector: ring of frame timestamps and clip matching sequencer.
// Depends on tcs_pkg and timestamp_clip_selector_top_macros.svh.
//
// Use: the slave stream takes one transaction per command. tuser is the opcode
// (push or query), tdata the 64-bit timestamp. A push stores the timestamp and
// returns nothing. A query returns one or more master transactions: tuser is the
// status, tdata holds position in [4:0] and matched time in [68:5], tlast marks
// the final one. Failures return one transaction with zero data. Config writes
// (index 0 clip_length, 1 stride_q8, 2 max_gap) are always taken.
// Timing: tready is high only while idle. The scan starts in the cycle after the
// query is accepted: per target a target step and a next step, and per ring entry
// scanned a read, a gap and a compare step. After the scan each result is read
// from the match memory, then from the ring, then loaded into the output register;
// the next result is fetched only after the receiver takes the current one. A
// failing target ends the scan at once; an empty ring or zero clip length answers
// in the cycle after acceptance. While the receiver stalls, the result is held and
// nothing new is taken. Reset (synchronous, active low) empties the ring and
// restores register defaults; the ring and match memories need no clearing.
`default_nettype none
`include "timestamp_clip_selector_top_macros.svh"

module timestamp_clip_selector_top #(
    parameter int CAPACITY = 32,
    parameter int MAX_CLIP = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,   // [63:0] timestamp
    input  wire logic        i_s_axis_tuser,   // [0] opcode
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [71:0]      o_m_axis_tdata,   // [4:0] position, [68:5] matched_time
    output logic [1:0]       o_m_axis_tuser,   // [1:0] status
    output logic             o_m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int PW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = $clog2(MAX_CLIP + 1);
    localparam int MW = (MAX_CLIP > 1) ? $clog2(MAX_CLIP) : 1;
    localparam logic [PW:0]   CAP_P   = (PW+1)'(CAPACITY);
    localparam logic [FW-1:0] CAP_F   = FW'(CAPACITY);
    localparam logic [PW-1:0] CAP_TOP = PW'(CAPACITY - 1);
    localparam logic [6:0]    CLIP_MX = 7'(MAX_CLIP);

    tcs_pkg::t_state r_state, n_state;

    // config
    logic [5:0]  r_clip_length;
    logic [31:0] r_stride_q8, r_max_gap;

    // ring control
    logic [FW-1:0] r_fill, n_fill;
    logic [PW-1:0] r_oldest, n_oldest;

    // query datapath
    logic [63:0]              r_ts, n_ts;
    logic [63:0]              r_target, n_target;
    logic [tcs_pkg::ACC_W-1:0] r_acc, n_acc;
    logic [tcs_pkg::BEST_W-1:0] r_best, n_best;
    logic [63:0]              r_gap, n_gap;
    logic [FW-1:0]            r_pos, n_pos;
    logic                     r_found, n_found;
    logic [CW-1:0]            r_n, n_n;
    logic [MW-1:0]            r_ms_idx, n_ms_idx;
    logic [CW-1:0]            r_j, n_j;

    // result register
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_out_status, n_out_status;
    logic [4:0]  r_out_pos, n_out_pos;
    logic [63:0] r_out_time, n_out_time;
    logic        r_out_last, n_out_last;

    // memories
    logic [63:0]   r_ring [CAPACITY];
    logic [63:0]   r_ring_rdata;
    logic [PW-1:0] r_ms [MAX_CLIP];
    logic [PW-1:0] r_ms_rdata;

    logic          w_ring_we;
    logic [PW-1:0] w_ring_waddr;
    logic [PW-1:0] w_ring_raddr;
    logic          w_ms_we;
    logic [MW-1:0] w_ms_raddr;

    logic          w_in_acc;
    logic [6:0]    w_clip7;
    logic [6:0]    w_n7;
    logic [PW+4:0] w_pos_wide;
    logic [FW-1:0] w_pos_dec;
    logic          w_gap_lt_best;
    logic          w_gap_lt_max;

    function automatic logic [PW-1:0] f_phys(input logic [PW-1:0] base,
                                             input logic [PW-1:0] off);
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= CAP_P) begin
            sum = sum - CAP_P;
        end
        return sum[PW-1:0];
    endfunction

    assign o_s_axis_tready = (r_state == tcs_pkg::ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out_time, r_out_pos};
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_clip7    = {1'b0, r_clip_length};
    assign w_n7       = (w_clip7 > CLIP_MX) ? CLIP_MX : w_clip7;
    assign w_pos_wide = {5'd0, r_ms_rdata};
    assign w_pos_dec  = r_pos - FW'(1);
    assign w_ms_raddr = r_j[MW-1:0];

    assign w_gap_lt_best = (r_gap[63:tcs_pkg::BEST_W] == '0) &&
                           (r_gap[tcs_pkg::BEST_W-1:0] < r_best);
    assign w_gap_lt_max  = (r_gap[63:32] == '0) && (r_gap[31:0] < r_max_gap);

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_oldest     = r_oldest;
        n_ts         = r_ts;
        n_target     = r_target;
        n_acc        = r_acc;
        n_best       = r_best;
        n_gap        = r_gap;
        n_pos        = r_pos;
        n_found      = r_found;
        n_n          = r_n;
        n_ms_idx     = r_ms_idx;
        n_j          = r_j;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_time   = r_out_time;
        n_out_last   = r_out_last;
        w_ring_we    = 1'b0;
        w_ring_waddr = r_oldest;
        w_ring_raddr = f_phys(r_oldest, w_pos_dec[PW-1:0]);
        w_ms_we      = 1'b0;

        case (r_state)
            tcs_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_s_axis_tuser == tcs_pkg::OP_PUSH) begin
                        w_ring_we = 1'b1;
                        if (r_fill == CAP_F) begin
                            w_ring_waddr = r_oldest;
                            n_oldest     = (r_oldest == CAP_TOP) ? '0 : r_oldest + PW'(1);
                        end else begin
                            w_ring_waddr = f_phys(r_oldest, r_fill[PW-1:0]);
                            n_fill       = r_fill + FW'(1);
                        end
                    end else begin
                        n_n          = CW'(w_n7);
                        n_ts         = i_s_axis_tdata;
                        n_acc        = '0;
                        n_ms_idx     = MW'(w_n7 - 7'd1);
                        n_out_pos    = '0;
                        n_out_time   = '0;
                        n_out_last   = 1'b1;
                        if (w_n7 == '0) begin
                            n_out_valid  = 1'b1;
                            n_out_status = tcs_pkg::STAT_UNMATCHED;
                            n_state      = tcs_pkg::ST_EMIT;
                        end else if (r_fill == '0) begin
                            n_out_valid  = 1'b1;
                            n_out_status = tcs_pkg::STAT_EMPTY;
                            n_state      = tcs_pkg::ST_EMIT;
                        end else begin
                            n_state = tcs_pkg::ST_TGT;
                        end
                    end
                end
            end
            tcs_pkg::ST_TGT: begin
                n_target = r_ts - {34'd0, r_acc[tcs_pkg::ACC_W-1:8]};
                n_best   = tcs_pkg::GAP_START;
                n_found  = 1'b0;
                n_pos    = r_fill;
                n_state  = tcs_pkg::ST_READ;
            end
            tcs_pkg::ST_READ: begin
                w_ring_raddr = f_phys(r_oldest, w_pos_dec[PW-1:0]);
                n_pos        = w_pos_dec;
                n_state      = tcs_pkg::ST_GAP;
            end
            tcs_pkg::ST_GAP: begin
                n_gap   = (r_ring_rdata > r_target) ? r_ring_rdata - r_target
                                                    : r_target - r_ring_rdata;
                n_state = tcs_pkg::ST_CMP;
            end
            tcs_pkg::ST_CMP: begin
                if (w_gap_lt_best) begin
                    n_best = r_gap[tcs_pkg::BEST_W-1:0];
                    if (w_gap_lt_max) begin
                        w_ms_we = 1'b1;
                        n_found = 1'b1;
                    end
                    n_state = (r_pos != '0) ? tcs_pkg::ST_READ : tcs_pkg::ST_NEXT;
                end else begin
                    n_state = tcs_pkg::ST_NEXT;
                end
            end
            tcs_pkg::ST_NEXT: begin
                if (!r_found) begin
                    n_out_valid  = 1'b1;
                    n_out_status = tcs_pkg::STAT_UNMATCHED;
                    n_out_pos    = '0;
                    n_out_time   = '0;
                    n_out_last   = 1'b1;
                    n_state      = tcs_pkg::ST_EMIT;
                end else if (r_ms_idx == '0) begin
                    n_j     = '0;
                    n_state = tcs_pkg::ST_OUT_MS;
                end else begin
                    n_ms_idx = r_ms_idx - MW'(1);
                    n_acc    = r_acc + {6'd0, r_stride_q8};
                    n_state  = tcs_pkg::ST_TGT;
                end
            end
            tcs_pkg::ST_OUT_MS: begin
                n_state = tcs_pkg::ST_OUT_RING;
            end
            tcs_pkg::ST_OUT_RING: begin
                w_ring_raddr = f_phys(r_oldest, r_ms_rdata);
                n_state      = tcs_pkg::ST_OUT_LOAD;
            end
            tcs_pkg::ST_OUT_LOAD: begin
                n_out_valid  = 1'b1;
                n_out_status = tcs_pkg::STAT_MATCH;
                n_out_pos    = w_pos_wide[4:0];
                n_out_time   = r_ring_rdata;
                n_out_last   = ((r_j + CW'(1)) == r_n);
                n_state      = tcs_pkg::ST_EMIT;
            end
            tcs_pkg::ST_EMIT: begin
                if (i_m_axis_tready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = tcs_pkg::ST_IDLE;
                    end else begin
                        n_j     = r_j + CW'(1);
                        n_state = tcs_pkg::ST_OUT_MS;
                    end
                end
            end
            default: begin
                n_state = tcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill        <= '0;
            r_oldest      <= '0;
            r_out_valid   <= 1'b0;
            r_clip_length <= 6'd16;
            r_stride_q8   <= 32'd8533;
            r_max_gap     <= 32'd50;
        end else begin
            r_fill      <= n_fill;
            r_oldest    <= n_oldest;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tcs_pkg::CFG_CLIP_LENGTH: r_clip_length <= i_cfg_data[5:0];
                    tcs_pkg::CFG_STRIDE_Q8:   r_stride_q8   <= i_cfg_data;
                    tcs_pkg::CFG_MAX_GAP:     r_max_gap     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ts         <= n_ts;
        r_target     <= n_target;
        r_acc        <= n_acc;
        r_best       <= n_best;
        r_gap        <= n_gap;
        r_pos        <= n_pos;
        r_found      <= n_found;
        r_n          <= n_n;
        r_ms_idx     <= n_ms_idx;
        r_j          <= n_j;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_time   <= n_out_time;
        r_out_last   <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_ring_we) begin
            r_ring[w_ring_waddr] <= i_s_axis_tdata;
        end
        r_ring_rdata <= r_ring[w_ring_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_ms_we) begin
            r_ms[r_ms_idx] <= r_pos[PW-1:0];
        end
        r_ms_rdata <= r_ms[w_ms_raddr];
    end

    `TCS_ASSERT(a_fill_bound, (r_fill <= CAP_F), "fill count above capacity")
    `TCS_ASSERT(a_oldest_full, (r_oldest != '0) |-> (r_fill == CAP_F), "oldest moved early")
    `TCS_ASSERT(a_no_accept_busy, o_m_axis_tvalid |-> !o_s_axis_tready, "input taken while busy")
    `TCS_ASSERT(a_scan_nonempty, (r_state == tcs_pkg::ST_TGT) |-> (r_fill != '0), "empty scan")
    `TCS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for timestamp_clip_selector_top: directed table, then random phases.
// Depends on tcs_pkg and the RTL; keeps its own clip predictor and checks every response.
`timescale 1ns / 100ps

module testbench;

    localparam int CAPACITY    = 32;
    localparam int MAX_CLIP    = 32;
    localparam int QUIET_LIMIT = 20000;
    localparam int IDLE_PAUSE  = 8;
    localparam int END_PAUSE   = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT_A   = 60;
    localparam int HOLD_AT_B   = 200;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 37;
    localparam logic [63:0] START_GAP = 64'd10000000000;
    localparam logic [1:0]  CFG_NONE  = 2'd3;
    localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  pos;
        logic [63:0] mtime;
        logic        last;
    } t_clip_rsp;

    typedef enum logic [1:0] {ROW_PUSH, ROW_QUERY, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  idx;
        logic [63:0] val;
        logic        typed;
        logic [1:0]  status;
    } t_dir_row;

    localparam int DIR_ROWS = 25;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_QUERY, CFG_NONE, 64'd0, 1'b1, tcs_pkg::STAT_EMPTY},
        '{ROW_CFG, tcs_pkg::CFG_CLIP_LENGTH, 64'd0, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_QUERY, CFG_NONE, ALL_ONES, 1'b1, tcs_pkg::STAT_UNMATCHED},
        '{ROW_CFG, tcs_pkg::CFG_CLIP_LENGTH, 64'd1, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_PUSH, CFG_NONE, 64'd0, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_PUSH, CFG_NONE, ALL_ONES, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_QUERY, CFG_NONE, ALL_ONES, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_QUERY, CFG_NONE, 64'd0, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_CFG, tcs_pkg::CFG_STRIDE_Q8, 64'hFFFF_FFFF, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_CFG, tcs_pkg::CFG_CLIP_LENGTH, 64'hFFFF_FFFF, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_QUERY, CFG_NONE, 64'h0000_00FF_FFFF_FFFF, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_CFG, tcs_pkg::CFG_MAX_GAP, 64'd0, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_QUERY, CFG_NONE, ALL_ONES, 1'b1, tcs_pkg::STAT_UNMATCHED},
        '{ROW_CFG, tcs_pkg::CFG_MAX_GAP, 64'hFFFF_FFFF, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_CFG, tcs_pkg::CFG_STRIDE_Q8, 64'd0, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_CFG, tcs_pkg::CFG_CLIP_LENGTH, 64'd5, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_CFG, CFG_NONE, 64'd2, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_PUSH, CFG_NONE, 64'd100, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_PUSH, CFG_NONE, 64'd200, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_QUERY, CFG_NONE, 64'd190, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_CFG, tcs_pkg::CFG_STRIDE_Q8, 64'd25600, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_CFG, tcs_pkg::CFG_CLIP_LENGTH, 64'd3, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_CFG, tcs_pkg::CFG_MAX_GAP, 64'd50, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_QUERY, CFG_NONE, 64'd200, 1'b0, tcs_pkg::STAT_MATCH},
        '{ROW_QUERY, CFG_NONE, 64'h8000_0000_0000_0000, 1'b0, tcs_pkg::STAT_MATCH}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        cmd_valid;
    logic        cmd_ready;
    logic [63:0] cmd_data;
    logic        cmd_op;
    logic        rsp_valid;
    logic        rsp_ready;
    logic [71:0] rsp_data;
    logic [1:0]  rsp_status;
    logic        rsp_last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // predictor state
    logic [63:0] ring_ts [CAPACITY];
    int          ring_head;
    int          ring_fill;
    logic [5:0]  clip_len_reg;
    logic [31:0] stride_reg;
    logic [31:0] gap_limit_reg;

    t_clip_rsp expected_clip_q [$];
    int        mismatches;
    int        sent_count;
    int        rx_count;

    timestamp_clip_selector_top #(
        .CAPACITY(CAPACITY),
        .MAX_CLIP(MAX_CLIP)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(cmd_valid),
        .o_s_axis_tready(cmd_ready),
        .i_s_axis_tdata (cmd_data),
        .i_s_axis_tuser (cmd_op),
        .o_m_axis_tvalid(rsp_valid),
        .i_m_axis_tready(rsp_ready),
        .o_m_axis_tdata (rsp_data),
        .o_m_axis_tuser (rsp_status),
        .o_m_axis_tlast (rsp_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // append one expected response transaction
    task automatic queue_rsp(input t_clip_rsp item);
        expected_clip_q.insert(expected_clip_q.size(), item);
    endtask

    // push: store in ring; query: queue the expected clip responses
    task automatic model_command(input logic op, input logic [63:0] ts);
        int          n;
        int          k;
        int          p;
        logic [63:0] target;
        logic [63:0] v;
        logic [63:0] gap;
        logic [63:0] best;
        logic        found;
        logic        all_ok;
        logic [4:0]  picks [MAX_CLIP];
        if (op == tcs_pkg::OP_PUSH) begin
            if (ring_fill == CAPACITY) begin
                ring_ts[ring_head] = ts;
                ring_head = (ring_head + 1) % CAPACITY;
            end else begin
                ring_ts[(ring_head + ring_fill) % CAPACITY] = ts;
                ring_fill++;
            end
            return;
        end
        n = (clip_len_reg > MAX_CLIP) ? MAX_CLIP : int'(clip_len_reg);
        if (n == 0) begin
            queue_rsp('{tcs_pkg::STAT_UNMATCHED, 5'd0, 64'd0, 1'b1});
            return;
        end
        if (ring_fill == 0) begin
            queue_rsp('{tcs_pkg::STAT_EMPTY, 5'd0, 64'd0, 1'b1});
            return;
        end
        all_ok = 1'b1;
        for (k = 0; k < n; k++) begin
            target = ts - ((64'(k) * 64'(stride_reg)) >> 8);
            found = 1'b0;
            best = START_GAP;
            p = ring_fill;
            while (p > 0) begin
                p--;
                v = ring_ts[(ring_head + p) % CAPACITY];
                gap = (v > target) ? v - target : target - v;
                if (gap < best) begin
                    best = gap;
                    if (gap < 64'(gap_limit_reg)) begin
                        picks[n - 1 - k] = p[4:0];
                        found = 1'b1;
                    end
                end else begin
                    break;
                end
            end
            if (!found) all_ok = 1'b0;
        end
        if (!all_ok) begin
            queue_rsp('{tcs_pkg::STAT_UNMATCHED, 5'd0, 64'd0, 1'b1});
            return;
        end
        for (k = 0; k < n; k++) begin
            queue_rsp('{tcs_pkg::STAT_MATCH, picks[k],
                ring_ts[(ring_head + int'(picks[k])) % CAPACITY], k == n - 1});
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s at %0t: expected %h, got %h", what, $realtime, want, got);
    endtask

    // one command transaction; typed rows carry their expected status directly
    task automatic send_cmd(input logic op, input logic [63:0] ts, input logic typed,
                            input logic [1:0] typed_status);
        int gap;
        gap = ((sent_count / 32) % 4 == 3) ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_valid <= 1'b1;
        cmd_op    <= op;
        cmd_data  <= ts;
        @(posedge i_clk);
        while (!cmd_ready) @(posedge i_clk);
        if (typed)
            queue_rsp('{typed_status, 5'd0, 64'd0, 1'b1});
        else
            model_command(op, ts);
        sent_count++;
        @(negedge i_clk);
    endtask

    // registers only change once the block has drained
    task automatic wait_idle(input int pause);
        cmd_valid <= 1'b0;
        while (expected_clip_q.size() != 0) @(negedge i_clk);
        repeat (pause) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        wait_idle(IDLE_PAUSE);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        case (idx)
            tcs_pkg::CFG_CLIP_LENGTH: clip_len_reg  = value[5:0];
            tcs_pkg::CFG_STRIDE_Q8:   stride_reg    = value;
            tcs_pkg::CFG_MAX_GAP:     gap_limit_reg = value;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // response side: random stalls, two long hold-offs to back the block up
    initial begin : rsp_sink
        int        gap;
        t_clip_rsp want;
        rsp_ready = 1'b0;
        rx_count  = 0;
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            gap = ((rx_count / 32) % 4 == 1) ? 0 : $urandom_range(0, 3);
            if (rx_count == HOLD_AT_A || rx_count == HOLD_AT_B) gap = HOLD_CYCLES;
            if (gap != 0) begin
                rsp_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            rsp_ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_valid) @(posedge i_clk);
            if (expected_clip_q.size() == 0) begin
                report_mismatch("unexpected transaction, tdata", 64'd0, rsp_data[63:0]);
            end else begin
                want = expected_clip_q.pop_front();
                if (rsp_status !== want.status)
                    report_mismatch("status", want.status, rsp_status);
                if (rsp_data[4:0] !== want.pos)
                    report_mismatch("position", want.pos, rsp_data[4:0]);
                if (rsp_data[68:5] !== want.mtime)
                    report_mismatch("matched_time", want.mtime, rsp_data[68:5]);
                if (rsp_last !== want.last)
                    report_mismatch("tlast", want.last, rsp_last);
            end
            rx_count++;
            @(negedge i_clk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int          r;
        int          ph;
        int          i;
        int          roll;
        logic [31:0] word;
        logic [63:0] step;
        logic [63:0] jit;
        logic [63:0] last_t;
        logic [31:0] clip_pick;
        logic [31:0] stride_pick;
        logic [31:0] gap_pick;
        i_rst_n       = 1'b0;
        cmd_valid     = 1'b0;
        cmd_op        = tcs_pkg::OP_PUSH;
        cmd_data      = 64'd0;
        cfg_valid     = 1'b0;
        cfg_index     = tcs_pkg::CFG_CLIP_LENGTH;
        cfg_data      = 32'd0;
        ring_head     = 0;
        ring_fill     = 0;
        clip_len_reg  = 6'd16;
        stride_reg    = 32'd8533;
        gap_limit_reg = 32'd50;
        mismatches    = 0;
        sent_count    = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (r = 0; r < DIR_ROWS; r++) begin
            case (dir_rows[r].kind)
                ROW_CFG:   cfg_write(dir_rows[r].idx, dir_rows[r].val[31:0]);
                ROW_PUSH:  send_cmd(tcs_pkg::OP_PUSH, dir_rows[r].val, 1'b0,
                                    tcs_pkg::STAT_MATCH);
                default:   send_cmd(tcs_pkg::OP_QUERY, dir_rows[r].val, dir_rows[r].typed,
                                    dir_rows[r].status);
            endcase
        end

        for (ph = 0; ph < PHASES; ph++) begin
            step = 64'($urandom_range(1, 100000));
            jit  = 64'($urandom_range(0, int'(step / 16)));
            case (ph)
                0:       clip_pick = 32;
                1:       clip_pick = 1;
                2:       clip_pick = 63;
                3:       clip_pick = 0;
                4:       clip_pick = $urandom_range(33, 63);
                default: clip_pick = $urandom_range(1, 24);
            endcase
            case (ph)
                1:       stride_pick = 32'd0;
                2:       stride_pick = 32'hFFFF_FFFF;
                default: stride_pick = 32'(step * 256) + $urandom_range(0, 255);
            endcase
            case (ph)
                5:       gap_pick = 32'd0;
                6:       gap_pick = 32'hFFFF_FFFF;
                default: gap_pick = $urandom_range(int'(jit) + 1, int'(step / 2 + jit) + 1);
            endcase
            // upper bits of the clip length write are don't-care
            word = $urandom;
            word[5:0] = clip_pick[5:0];
            cfg_write(tcs_pkg::CFG_CLIP_LENGTH, word);
            cfg_write(tcs_pkg::CFG_STRIDE_Q8, stride_pick);
            cfg_write(tcs_pkg::CFG_MAX_GAP, gap_pick);
            cfg_write(CFG_NONE, $urandom);
            case (ph % 3)
                0:       last_t = {$urandom, $urandom};
                1:       last_t = 64'($urandom_range(0, 5000));
                default: last_t = ALL_ONES - 64'($urandom_range(0, 3000000));
            endcase
            for (i = 0; i < PHASE_ITEMS; i++) begin
                roll = (i < 8) ? 50 : $urandom_range(0, 99);
                if (roll < 6) begin
                    send_cmd(1'($urandom_range(0, 1)), {$urandom, $urandom}, 1'b0,
                             tcs_pkg::STAT_MATCH);
                end else if (roll < 70) begin
                    last_t = last_t + step - jit + 64'($urandom_range(0, int'(2 * jit)));
                    send_cmd(tcs_pkg::OP_PUSH, last_t, 1'b0, tcs_pkg::STAT_MATCH);
                end else begin
                    send_cmd(tcs_pkg::OP_QUERY,
                             last_t - jit + 64'($urandom_range(0, int'(2 * jit))),
                             1'b0, tcs_pkg::STAT_MATCH);
                end
            end
        end

        wait_idle(END_PAUSE);
        if (mismatches == 0 && expected_clip_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
